// ===== hdl/rsi_pkg.sv =====
// Shared widths, payload types and sideband types for the ray/sphere intersection core.
`timescale 1ns / 1ps

package rsi_pkg;

    // fixed-point format of the coordinates
    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 32;

    // derived widths
    localparam int CW   = COORD_BITS;       // coordinate
    localparam int OCW  = CW + 1;           // origin minus centre
    localparam int AW   = 2 * CW;           // A = d.d, unsigned
    localparam int BW   = 2 * CW + 2;       // B = d.oc, signed
    localparam int CCW  = 2 * CW + 3;       // C = oc.oc - r*r, signed
    localparam int MW   = 2 * CW + 2;       // multiplier operand magnitude
    localparam int MDW  = (MW + 2) / 3;     // multiplier digit
    localparam int PW   = 3 * MDW;          // padded multiplier operand
    localparam int DW   = 4 * CW + 3;       // discriminant, signed
    localparam int SQW  = 2 * CW + 1;       // square root result
    localparam int RW   = 2 * SQW + 1;      // square root remainder
    localparam int NW   = 2 * CW + 3;       // numerator before scaling, signed
    localparam int NMW  = 2 * CW + 2;       // numerator magnitude
    localparam int QNW  = NMW + FRAC_BITS;  // scaled numerator and quotient

    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic        [CW-2:0] sphere_radius;
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic signed [CW-1:0] hit_distance;
        logic                 missed;
        logic                 zero_direction;
        logic                 overflowed;
    } t_hit;

    // carried alongside the square root pipeline
    typedef struct packed {
        logic [AW-1:0] a;
        logic [BW-1:0] b;
        logic          miss;
        logic          zdir;
    } t_sq_side;

    // carried alongside the divider pipeline
    typedef struct packed {
        logic neg;
        logic miss;
        logic zdir;
    } t_dv_side;

endpackage

// ===== hdl/rsi_if.sv =====
// Valid/ready channel interfaces for ray items and hit items.
`timescale 1ns / 1ps

interface rsi_ray_if;
    import rsi_pkg::*;
    logic valid;
    logic ready;
    t_ray data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rsi_hit_if;
    import rsi_pkg::*;
    logic valid;
    logic ready;
    t_hit data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/rsi_mul.sv =====
// Two-stage unsigned multiplier: registered digit products, then a registered sum.
`timescale 1ns / 1ps

module rsi_mul (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rsi_pkg::MW-1:0]      i_a,
    input  logic [rsi_pkg::MW-1:0]      i_b,
    output logic [2*rsi_pkg::MW-1:0]    o_p
);
    import rsi_pkg::*;

    logic [PW-1:0]      a_pad;
    logic [PW-1:0]      b_pad;
    logic [2*MDW-1:0]   r_pp [3][3];
    logic [2*PW-1:0]    n_sum;
    logic [2*MW-1:0]    r_p;

    assign a_pad = PW'(i_a);
    assign b_pad = PW'(i_b);

    // form the nine digit products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pp[i][j] <= a_pad[i*MDW +: MDW] * b_pad[j*MDW +: MDW];
                end
            end
        end
    end

    // add the shifted products
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_sum = n_sum + ((2*PW)'(r_pp[i][j]) << ((i + j) * MDW));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_sum[2*MW-1:0];
        end
    end

    assign o_p = r_p;

endmodule

// ===== hdl/rsi_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module rsi_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [rsi_pkg::DW-2:0]      i_rad,
    input  rsi_pkg::t_sq_side           i_side,
    output logic                        o_valid,
    output logic [rsi_pkg::SQW-1:0]     o_root,
    output rsi_pkg::t_sq_side           o_side
);
    import rsi_pkg::*;

    logic             r_v    [SQW];
    logic [RW-1:0]    r_rem  [SQW];
    logic [SQW-1:0]   r_root [SQW];
    t_sq_side         r_side [SQW];

    logic             in_v    [SQW];
    logic [RW-1:0]    in_rem  [SQW];
    logic [SQW-1:0]   in_root [SQW];
    t_sq_side         in_side [SQW];

    for (genvar k = 0; k < SQW; k++) begin : g_stage
        localparam int B = SQW - 1 - k;
        logic [RW-1:0]  trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign in_v[k]    = i_valid;
            assign in_rem[k]  = RW'(i_rad);
            assign in_root[k] = '0;
            assign in_side[k] = i_side;
        end else begin : g_next
            assign in_v[k]    = r_v[k-1];
            assign in_rem[k]  = r_rem[k-1];
            assign in_root[k] = r_root[k-1];
            assign in_side[k] = r_side[k-1];
        end

        // try setting this bit of the root
        assign trial = (RW'(in_root[k]) << (B + 1)) + (RW'(1) << (2 * B));
        assign ge    = in_rem[k] >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= in_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? in_rem[k] - trial : in_rem[k];
                r_root[k] <= in_root[k] | (SQW'(ge) << B);
                r_side[k] <= in_side[k];
            end
        end
    end

    assign o_valid = r_v[SQW-1];
    assign o_root  = r_root[SQW-1];
    assign o_side  = r_side[SQW-1];

endmodule

// ===== hdl/rsi_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
`timescale 1ns / 1ps

module rsi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [rsi_pkg::QNW-1:0]     i_num,
    input  logic [rsi_pkg::AW-1:0]      i_den,
    input  rsi_pkg::t_dv_side           i_side,
    output logic                        o_valid,
    output logic [rsi_pkg::QNW-1:0]     o_quot,
    output rsi_pkg::t_dv_side           o_side
);
    import rsi_pkg::*;

    logic             r_v    [QNW];
    logic [QNW-1:0]   r_num  [QNW];
    logic [AW-1:0]    r_den  [QNW];
    logic [AW-1:0]    r_rem  [QNW];
    logic [QNW-1:0]   r_quot [QNW];
    t_dv_side         r_side [QNW];

    logic             in_v    [QNW];
    logic [QNW-1:0]   in_num  [QNW];
    logic [AW-1:0]    in_den  [QNW];
    logic [AW-1:0]    in_rem  [QNW];
    logic [QNW-1:0]   in_quot [QNW];
    t_dv_side         in_side [QNW];

    for (genvar k = 0; k < QNW; k++) begin : g_stage
        localparam int B = QNW - 1 - k;
        logic [AW:0]  shifted;
        logic [AW:0]  diff;
        logic         ge;

        if (k == 0) begin : g_first
            assign in_v[k]    = i_valid;
            assign in_num[k]  = i_num;
            assign in_den[k]  = i_den;
            assign in_rem[k]  = '0;
            assign in_quot[k] = '0;
            assign in_side[k] = i_side;
        end else begin : g_next
            assign in_v[k]    = r_v[k-1];
            assign in_num[k]  = r_num[k-1];
            assign in_den[k]  = r_den[k-1];
            assign in_rem[k]  = r_rem[k-1];
            assign in_quot[k] = r_quot[k-1];
            assign in_side[k] = r_side[k-1];
        end

        // bring down the next numerator bit and try a subtract
        assign shifted = {in_rem[k], in_num[k][B]};
        assign diff    = shifted - {1'b0, in_den[k]};
        assign ge      = shifted >= {1'b0, in_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= in_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= in_num[k];
                r_den[k]  <= in_den[k];
                r_rem[k]  <= ge ? diff[AW-1:0] : shifted[AW-1:0];
                r_quot[k] <= in_quot[k] | (QNW'(ge) << B);
                r_side[k] <= in_side[k];
            end
        end
    end

    assign o_valid = r_v[QNW-1];
    assign o_quot  = r_quot[QNW-1];
    assign o_side  = r_side[QNW-1];

endmodule

// ===== hdl/ray_sphere_intersect_core.sv =====
// Top level of the ray/sphere intersection core: coefficient, discriminant, root and divide pipeline.
//
//  Channel | Dir | Handshake             | Carries
//  i_ray   | in  | valid/ready, rsi_pkg  | sphere centre, radius, ray origin, direction
//  o_hit   | out | valid/ready, rsi_pkg  | hit distance, miss, zero direction, overflow
//
// One item enters per cycle unless the output is stalled; each item passes through
// 1 input stage, 2 x 3 multiplier/sum stages, 65 square root stages, 1 numerator
// stage, 82 divider stages and 1 output register; the divider sets most of the depth.
// Reset is synchronous and clears only the valid bits; no item is taken during reset.
// A stalled output freezes every stage together; out of reset, ready is high whenever
// the output register is empty or being taken.
`timescale 1ns / 1ps

module ray_sphere_intersect_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rsi_ray_if.sink      i_ray,
    rsi_hit_if.source    o_hit
);
    import rsi_pkg::*;

    logic en;

    // input stage
    logic                   r_p0_v;
    logic [OCW-1:0]         r_oc [3];
    logic [CW-1:0]          r_d  [3];
    logic [CW-2:0]          r_r;

    logic [CW-1:0]          dir_in [3];
    logic [CW-1:0]          org_in [3];
    logic [CW-1:0]          ctr_in [3];

    logic [CW-1:0]          d_mag  [3];
    logic [OCW-1:0]         oc_mag [3];
    logic [2:0]             doc_sg;

    logic [2*MW-1:0]        p_dd   [3];
    logic [2*MW-1:0]        p_doc  [3];
    logic [2*MW-1:0]        p_ococ [3];
    logic [2*MW-1:0]        p_rr;

    logic                   r_m1_v, r_m2_v;
    logic [2:0]             r_m1_sg, r_m2_sg;

    // coefficient stage
    logic [AW-1:0]          n_a;
    logic [BW-1:0]          n_b;
    logic [CCW-1:0]         n_c;
    logic                   r_p3_v;
    logic [AW-1:0]          r_p3_a;
    logic [BW-1:0]          r_p3_b;
    logic [CCW-1:0]         r_p3_c;
    logic [BW-1:0]          b_mag;
    logic [CCW-1:0]         c_mag;

    logic [2*MW-1:0]        p_bb, p_ac;
    logic                   r_q1_v, r_q2_v;
    logic                   r_q1_cneg, r_q2_cneg;
    t_sq_side               r_q1_side, r_q2_side;

    // discriminant stage
    logic [DW-1:0]          n_disc;
    logic                   r_p4_v;
    logic [DW-1:0]          r_p4_d;
    t_sq_side               r_p4_side;
    logic [DW-2:0]          rad;

    logic                   sq_v;
    logic [SQW-1:0]         sq_root;
    t_sq_side               sq_side;

    // numerator stage
    logic [NW-1:0]          nb, sroot, n_lo, n_sel;
    logic [NMW-1:0]         n_mag;
    logic                   r_p5_v;
    logic [QNW-1:0]         r_p5_num;
    logic [AW-1:0]          r_p5_den;
    t_dv_side               r_p5_side;

    logic                   dv_v;
    logic [QNW-1:0]         dv_quot;
    t_dv_side               dv_side;

    // output stage
    logic [QNW-1:0]         q_mag, q_lim, q_sat;
    logic                   q_neg, q_ovf;
    t_hit                   n_hit;
    logic                   r_out_v;
    t_hit                   r_out;

    // advance everything unless the output holds an item nobody takes
    assign en          = !r_out_v || o_hit.ready;
    assign i_ray.ready = en && i_rst_n;

    assign dir_in[0] = i_ray.data.dir_x;
    assign dir_in[1] = i_ray.data.dir_y;
    assign dir_in[2] = i_ray.data.dir_z;
    assign org_in[0] = i_ray.data.origin_x;
    assign org_in[1] = i_ray.data.origin_y;
    assign org_in[2] = i_ray.data.origin_z;
    assign ctr_in[0] = i_ray.data.center_x;
    assign ctr_in[1] = i_ray.data.center_y;
    assign ctr_in[2] = i_ray.data.center_z;

    // capture the ray and form origin minus centre
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i]  <= dir_in[i];
                r_oc[i] <= {org_in[i][CW-1], org_in[i]} - {ctr_in[i][CW-1], ctr_in[i]};
            end
            r_r <= i_ray.data.sphere_radius;
        end
    end

    // magnitudes and product signs for the first multiplier bank
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_mag[i]  = r_d[i][CW-1] ? (~r_d[i] + 1'b1) : r_d[i];
            oc_mag[i] = r_oc[i][OCW-1] ? (~r_oc[i] + 1'b1) : r_oc[i];
            doc_sg[i] = r_d[i][CW-1] ^ r_oc[i][OCW-1];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_axis
        rsi_mul u_mul_dd (
            .i_clk (i_clk), .i_en (en),
            .i_a (MW'(d_mag[i])), .i_b (MW'(d_mag[i])), .o_p (p_dd[i])
        );
        rsi_mul u_mul_doc (
            .i_clk (i_clk), .i_en (en),
            .i_a (MW'(d_mag[i])), .i_b (MW'(oc_mag[i])), .o_p (p_doc[i])
        );
        rsi_mul u_mul_ococ (
            .i_clk (i_clk), .i_en (en),
            .i_a (MW'(oc_mag[i])), .i_b (MW'(oc_mag[i])), .o_p (p_ococ[i])
        );
    end

    rsi_mul u_mul_rr (
        .i_clk (i_clk), .i_en (en),
        .i_a (MW'(r_r)), .i_b (MW'(r_r)), .o_p (p_rr)
    );

    // carry signs alongside the first multiplier bank
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_sg <= doc_sg;
            r_m2_sg <= r_m1_sg;
        end
    end

    // sum the dot products
    always_comb begin
        n_a = '0;
        n_b = '0;
        n_c = '0;
        for (int i = 0; i < 3; i++) begin
            n_a = n_a + p_dd[i][AW-1:0];
            n_b = r_m2_sg[i] ? n_b - p_doc[i][BW-1:0] : n_b + p_doc[i][BW-1:0];
            n_c = n_c + p_ococ[i][CCW-1:0];
        end
        n_c = n_c - p_rr[CCW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p3_a <= n_a;
            r_p3_b <= n_b;
            r_p3_c <= n_c;
        end
    end

    assign b_mag = r_p3_b[BW-1] ? (~r_p3_b + 1'b1) : r_p3_b;
    assign c_mag = r_p3_c[CCW-1] ? (~r_p3_c + 1'b1) : r_p3_c;

    rsi_mul u_mul_bb (
        .i_clk (i_clk), .i_en (en),
        .i_a (MW'(b_mag)), .i_b (MW'(b_mag)), .o_p (p_bb)
    );
    rsi_mul u_mul_ac (
        .i_clk (i_clk), .i_en (en),
        .i_a (MW'(r_p3_a)), .i_b (c_mag[MW-1:0]), .o_p (p_ac)
    );

    // carry A, B and the sign of C alongside the second multiplier bank
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1_cneg      <= r_p3_c[CCW-1];
            r_q1_side.a    <= r_p3_a;
            r_q1_side.b    <= r_p3_b;
            r_q1_side.miss <= 1'b0;
            r_q1_side.zdir <= 1'b0;
            r_q2_cneg      <= r_q1_cneg;
            r_q2_side      <= r_q1_side;
        end
    end

    // discriminant B*B - A*C
    assign n_disc = r_q2_cneg ? p_bb[DW-1:0] + p_ac[DW-1:0]
                              : p_bb[DW-1:0] - p_ac[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p4_d         <= n_disc;
            r_p4_side.a    <= r_q2_side.a;
            r_p4_side.b    <= r_q2_side.b;
            r_p4_side.miss <= n_disc[DW-1];
            r_p4_side.zdir <= (r_q2_side.a == '0);
        end
    end

    // feed zero on a miss so the root stays bounded
    assign rad = r_p4_side.miss ? '0 : r_p4_d[DW-2:0];

    rsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p4_v),
        .i_rad   (rad),
        .i_side  (r_p4_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // pick the nearer root, or the farther one when the nearer is negative
    always_comb begin
        nb    = '0 - {sq_side.b[BW-1], sq_side.b};
        sroot = NW'(sq_root);
        n_lo  = nb - sroot;
        n_sel = n_lo[NW-1] ? nb + sroot : n_lo;
        n_mag = n_sel[NW-1] ? NMW'(~n_sel + 1'b1) : n_sel[NMW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p5_num       <= {n_mag, {FRAC_BITS{1'b0}}};
            r_p5_den       <= sq_side.a;
            r_p5_side.neg  <= n_sel[NW-1];
            r_p5_side.miss <= sq_side.miss;
            r_p5_side.zdir <= sq_side.zdir;
        end
    end

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p5_v),
        .i_num   (r_p5_num),
        .i_den   (r_p5_den),
        .i_side  (r_p5_side),
        .o_valid (dv_v),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    // saturate, apply the miss and zero direction cases
    always_comb begin
        q_neg = dv_side.miss || dv_side.neg;
        q_mag = dv_side.miss ? (QNW'(1) << FRAC_BITS) : dv_quot;
        q_lim = dv_side.miss || dv_side.neg ? (QNW'(1) << (CW - 1))
                                            : (QNW'(1) << (CW - 1)) - 1'b1;
        q_ovf = q_mag > q_lim;
        q_sat = q_ovf ? q_lim : q_mag;
        n_hit.missed         = dv_side.miss;
        n_hit.zero_direction = 1'b0;
        n_hit.overflowed     = q_ovf;
        n_hit.hit_distance   = q_neg ? CW'(~q_sat[CW-1:0] + 1'b1) : q_sat[CW-1:0];
        if (!dv_side.miss && dv_side.zdir) begin
            n_hit.zero_direction = 1'b1;
            n_hit.overflowed     = 1'b0;
            n_hit.hit_distance   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_hit;
        end
    end

    // valid bits of the top-level stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_v  <= 1'b0;
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_q1_v  <= 1'b0;
            r_q2_v  <= 1'b0;
            r_p4_v  <= 1'b0;
            r_p5_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_p0_v  <= i_ray.valid;
            r_m1_v  <= r_p0_v;
            r_m2_v  <= r_m1_v;
            r_p3_v  <= r_m2_v;
            r_q1_v  <= r_p3_v;
            r_q2_v  <= r_q1_v;
            r_p4_v  <= r_q2_v;
            r_p5_v  <= sq_v;
            r_out_v <= dv_v;
        end
    end

    assign o_hit.valid = r_out_v;
    assign o_hit.data  = r_out;

    // a zero direction can never also be a miss
    a_miss_zdir_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit.valid |-> !(o_hit.data.missed && o_hit.data.zero_direction))
        else $error("miss and zero direction flagged together");

    // zero direction gives a clean zero distance
    a_zdir_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit.valid && o_hit.data.zero_direction) |->
            (o_hit.data.hit_distance == '0 && !o_hit.data.overflowed))
        else $error("zero direction with nonzero distance or overflow");

    // a miss always reports a negative distance
    a_miss_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit.valid && o_hit.data.missed) |-> o_hit.data.hit_distance[CW-1])
        else $error("miss without negative distance");

endmodule

// ===== tb/tb_ray_sphere_intersect_core.sv =====
// Self-checking testbench for the ray/sphere intersection core.
`timescale 1ns / 1ps

module tb_ray_sphere_intersect_core;
    import rsi_pkg::*;

    localparam int  LATENCY   = 156;
    localparam int  CYCLE_CAP = 400000;
    localparam int  N_RANDOM  = 800;
    localparam real CLK_HALF  = 6.0;

    logic i_clk;
    logic i_rst_n;

    rsi_ray_if ray_ch ();
    rsi_hit_if hit_ch ();

    ray_sphere_intersect_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (ray_ch.sink),
        .o_hit   (hit_ch.source)
    );

    t_ray ray_pending[$];
    t_hit hit_expected[$];
    int   n_errors = 0;
    int   n_cycles = 0;
    bit   drive_done;
    bit   hold_for_drain;
    bit   quiet_src;
    bit   quiet_snk;

    // Exact hit prediction on wide signed integers
    function automatic t_hit predict_hit(t_ray r);
        logic signed [40:0]  ox, oy, oz;
        logic signed [260:0] a, b, c, d, s, n, q, rr;
        logic signed [260:0] lo, hi, mid;
        logic signed [260:0] half;
        t_hit h;
        bit neg;
        half = 261'sd1 <<< (COORD_BITS - 1);
        h = '0;
        ox = $signed(r.origin_x) - $signed(r.center_x);
        oy = $signed(r.origin_y) - $signed(r.center_y);
        oz = $signed(r.origin_z) - $signed(r.center_z);
        rr = $signed({1'b0, r.sphere_radius});
        a = $signed(r.dir_x) * $signed(r.dir_x) + $signed(r.dir_y) * $signed(r.dir_y)
            + $signed(r.dir_z) * $signed(r.dir_z);
        b = $signed(r.dir_x) * ox + $signed(r.dir_y) * oy + $signed(r.dir_z) * oz;
        c = ox * ox + oy * oy + oz * oz - rr * rr;
        d = b * b - a * c;
        if (d < 0) begin
            h.missed = 1'b1;
            h.hit_distance = -(32'sd1 <<< FRAC_BITS);
        end else if (a == 0) begin
            h.zero_direction = 1'b1;
        end else begin
            // floor square root by bisection
            lo = 0;
            hi = 261'sd1 <<< 130;
            while (hi - lo > 1) begin
                mid = (lo + hi) >>> 1;
                if (mid * mid <= d) lo = mid;
                else hi = mid;
            end
            s = lo;
            n = -b - s;
            if (n < 0) n = -b + s;
            neg = n < 0;
            if (neg) n = -n;
            q = (n <<< FRAC_BITS) / a;
            if (neg) begin
                if (q > half) begin
                    q = half;
                    h.overflowed = 1'b1;
                end
                q = -q;
            end else if (q > half - 1) begin
                q = half - 1;
                h.overflowed = 1'b1;
            end
            h.hit_distance = q[CW-1:0];
        end
        return h;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic logic [31:0] rand_word();
        unique case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: return $signed($urandom_range(0, 16 << 16)) - (8 << 16);
        endcase
    endfunction

    function automatic t_ray rand_ray();
        t_ray r;
        r.center_x = rand_word();
        r.center_y = rand_word();
        r.center_z = rand_word();
        r.origin_x = rand_word();
        r.origin_y = rand_word();
        r.origin_z = rand_word();
        r.dir_x = rand_word();
        r.dir_y = rand_word();
        r.dir_z = rand_word();
        if ($urandom_range(0, 3) == 0) r.sphere_radius = (CW-1)'($urandom());
        else r.sphere_radius = (CW-1)'($urandom_range(0, 6 << 16));
        if ($urandom_range(0, 19) == 0) {r.dir_x, r.dir_y, r.dir_z} = '0;
        return r;
    endfunction

    function automatic t_ray make_ray(int cx, int cz, int rad, int oz, int dz);
        t_ray r;
        r = '0;
        r.center_x = cx;
        r.center_z = cz;
        r.sphere_radius = (CW-1)'(rad);
        r.origin_z = oz;
        r.dir_z = dz;
        return r;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Stimulus queue and reset
    initial begin
        t_ray r;
        i_rst_n = 1'b0;
        hold_for_drain = 1'b0;
        // hits in front, sphere behind, origin inside, miss, tangent
        ray_pending = {ray_pending, make_ray(0, 10 << 16, 1 << 16, 0, 1 << 16)};
        ray_pending = {ray_pending, make_ray(0, -(10 << 16), 1 << 16, 0, 1 << 16)};
        ray_pending = {ray_pending, make_ray(0, 0, 2 << 16, 0, 1 << 16)};
        ray_pending = {ray_pending, make_ray(5 << 16, 10 << 16, 1 << 16, 0, 1 << 16)};
        ray_pending = {ray_pending, make_ray(1 << 16, 10 << 16, 1 << 16, 0, 1 << 16)};
        ray_pending = {ray_pending, make_ray(0, 10 << 16, 1 << 16, 0, 0)};
        ray_pending = {ray_pending, make_ray(0, 10 << 16, 1 << 16, 0, 1)};
        ray_pending = {ray_pending, make_ray(0, 32'h7fff_0000, 1 << 16, 32'h8000_0000, 1)};
        ray_pending = {ray_pending, make_ray(0, 32'h8000_0000, 1 << 16, 32'h7fff_0000, 1)};
        ray_pending = {ray_pending, make_ray(0, 10 << 16, 32'h7fff_ffff, 0, 1 << 16)};
        r = '1;
        r.sphere_radius = '1;
        ray_pending = {ray_pending, r};
        r = '0;
        r.center_x = 32'h8000_0000;
        r.origin_x = 32'h7fff_ffff;
        r.dir_x = 32'h8000_0000;
        r.dir_y = 32'h7fff_ffff;
        r.dir_z = 32'h8000_0000;
        ray_pending = {ray_pending, r};
        for (int i = 0; i < N_RANDOM; i++) ray_pending = {ray_pending, rand_ray()};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // pause the sender once until the pipeline has drained
        wait (ray_pending.size() < N_RANDOM / 2);
        hold_for_drain = 1'b1;
        wait (hit_expected.size() == 0);
        @(posedge i_clk);
        hold_for_drain = 1'b0;
    end

    // Driver: present the next item, hold it until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ray_ch.valid <= 1'b0;
            ray_ch.data  <= '0;
            quiet_src    <= 1'b0;
        end else begin
            quiet_src <= n_cycles > 150 && n_cycles < 450;
            if (ray_ch.valid && ray_ch.ready) begin
                hit_expected = {hit_expected, predict_hit(ray_ch.data)};
                void'(ray_pending.pop_front());
            end
            if (ray_ch.valid && !ray_ch.ready) begin
                // hold the item
            end else if (ray_pending.size() > (ray_ch.valid && ray_ch.ready ? 0 : 0)
                         && !hold_for_drain
                         && (quiet_src || $urandom_range(0, 99) >= 18)) begin
                ray_ch.valid <= 1'b1;
                ray_ch.data  <= ray_pending[0];
            end else begin
                ray_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: take hits and check against the oldest prediction
    always @(posedge i_clk) begin
        t_hit want;
        if (!i_rst_n) begin
            hit_ch.ready <= 1'b0;
            quiet_snk    <= 1'b0;
        end else begin
            quiet_snk <= n_cycles > 150 && n_cycles < 450;
            if (hit_ch.valid && hit_ch.ready) begin
                if (hit_expected.size() == 0) begin
                    report_mismatch("unexpected hit", hit_ch.data, '0);
                end else begin
                    want = hit_expected.pop_front();
                    if (hit_ch.data.hit_distance !== want.hit_distance)
                        report_mismatch("hit_distance", hit_ch.data.hit_distance,
                                        want.hit_distance);
                    if (hit_ch.data.missed !== want.missed)
                        report_mismatch("missed", hit_ch.data.missed, want.missed);
                    if (hit_ch.data.zero_direction !== want.zero_direction)
                        report_mismatch("zero_direction", hit_ch.data.zero_direction,
                                        want.zero_direction);
                    if (hit_ch.data.overflowed !== want.overflowed)
                        report_mismatch("overflowed", hit_ch.data.overflowed,
                                        want.overflowed);
                end
            end
            hit_ch.ready <= quiet_snk || $urandom_range(0, 99) >= 18;
        end
    end

    // Cycle count and run limit
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_CAP) begin
            $display("ray_sphere_intersect_core regression: fail");
            $finish;
        end
    end

    // Wait for drain, then conclude
    initial begin
        wait (i_rst_n);
        wait (ray_pending.size() == 0 && hit_expected.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0 && hit_expected.size() == 0) begin
            $display("ray_sphere_intersect_core regression: pass");
        end else begin
            $display("ray_sphere_intersect_core regression: fail");
        end
        $finish;
    end

endmodule
